[hw/rtl/rpd_pkg.sv]
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants of the radio packet deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpd_pkg;

  // Framing constants.
  localparam logic [7:0] AckNoneByte = 8'h00;
  localparam logic [7:0] AckAckByte  = 8'h0A;
  localparam logic [7:0] AckNackByte = 8'hFF;
  localparam logic [7:0] TypeMax     = 8'd8;
  localparam logic [7:0] HeaderLen   = 8'd8;

  // Configuration register indexes.
  localparam logic [2:0] CfgSyncFirst  = 3'd0;
  localparam logic [2:0] CfgSyncSecond = 3'd1;
  localparam logic [2:0] CfgDirIn      = 3'd2;
  localparam logic [2:0] CfgDirOut     = 3'd3;
  localparam logic [2:0] CfgDataType   = 3'd4;

  typedef enum logic [1:0] {
    PhHunt    = 2'd0,
    PhHeader  = 2'd1,
    PhPayload = 2'd2,
    PhPsum    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RoleDiscard = 2'd0,
    RoleHeader  = 2'd1,
    RolePayload = 2'd2,
    RolePsum    = 2'd3
  } role_e;

  typedef enum logic [2:0] {
    StPending = 3'd0,
    StOk      = 3'd1,
    StBadSync = 3'd2,
    StBadDir  = 3'd3,
    StBadType = 3'd4,
    StBadAck  = 3'd5,
    StBadHsum = 3'd6,
    StBadPsum = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    AckPlain = 2'd0,
    AckAck   = 2'd1,
    AckNack  = 2'd2
  } ack_e;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] dir_code_in;
    logic [7:0] dir_code_out;
    logic [3:0] data_type_code;
  } cfg_t;

  // Frame tracking state.
  typedef struct packed {
    phase_e     phase;
    logic [7:0] byte_index;
    logic [7:0] sum_low;
    logic [7:0] sum_high;
    logic [3:0] held_type;
    ack_e       held_ack;
    logic [7:0] held_length;
    logic       low_sum_matched;
  } state_t;

  // One result item.
  typedef struct packed {
    logic [7:0] data_byte;
    role_e      byte_role;
    logic       frame_end;
    status_e    status;
    logic [3:0] frame_type;
    logic [1:0] ack_kind;
    logic [7:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/rpd_step.sv]
// ----------------------------------------------------------------------------
// rpd_step
// Per-byte framing logic: next state and result item for one received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpd_step
  import rpd_pkg::*;
(
  input  cfg_t       cfg_i,
  input  state_t     state_i,
  input  logic [7:0] rx_byte_i,
  output state_t     state_o,
  output result_t    result_o
);

  logic [7:0] b;
  logic [7:0] low_add;
  logic [7:0] high_add;
  logic [7:0] idx_inc;
  assign b = rx_byte_i;

  // Fletcher-8 running sums with this byte added.
  assign low_add  = state_i.sum_low + b;
  assign high_add = state_i.sum_high + low_add;
  assign idx_inc  = state_i.byte_index + 8'd1;

  always_comb begin
    state_t  s;
    role_e   role;
    status_e status;
    logic    fend;
    logic    show;
    s      = state_i;
    role   = RoleDiscard;
    status = StPending;
    fend   = 1'b0;
    show   = 1'b1;

    case (state_i.phase)
      PhHunt: begin
        if (b == cfg_i.sync_first) begin
          role              = RoleHeader;
          s.held_type       = 4'd0;
          s.held_ack        = AckPlain;
          s.held_length     = 8'd0;
          s.low_sum_matched = 1'b0;
          s.sum_low         = 8'd0;
          s.sum_high        = 8'd0;
          s.byte_index      = 8'd1;
          s.phase           = PhHeader;
        end else begin
          show = 1'b0;
        end
      end
      PhHeader: begin
        role = RoleHeader;
        case (state_i.byte_index)
          8'd1: begin
            if (b != cfg_i.sync_second) status = StBadSync;
          end
          8'd2: begin
            if (b != cfg_i.dir_code_in && b != cfg_i.dir_code_out) begin
              status = StBadDir;
            end else begin
              s.sum_low  = low_add;
              s.sum_high = high_add;
            end
          end
          8'd3: begin
            if (b < 8'd1 || b > TypeMax) begin
              status = StBadType;
            end else begin
              s.held_type = b[3:0];
              s.sum_low   = low_add;
              s.sum_high  = high_add;
            end
          end
          8'd4: begin
            if (b == AckNoneByte || b == AckAckByte || b == AckNackByte) begin
              s.sum_low  = low_add;
              s.sum_high = high_add;
            end else begin
              status = StBadAck;
            end
            if (b == AckNoneByte) s.held_ack = AckPlain;
            else if (b == AckAckByte) s.held_ack = AckAck;
            else if (b == AckNackByte) s.held_ack = AckNack;
          end
          8'd5: begin
            s.held_length = b;
            s.sum_low     = low_add;
            s.sum_high    = high_add;
          end
          8'd6: begin
            s.low_sum_matched = (b == state_i.sum_low);
          end
          default: begin
            // Header sum is judged on both bytes at the last header byte.
            if (!state_i.low_sum_matched || b != state_i.sum_high) begin
              status = StBadHsum;
            end else if (state_i.held_type == cfg_i.data_type_code &&
                         state_i.held_ack == AckPlain &&
                         state_i.held_length != 8'd0) begin
              s.phase      = PhPayload;
              s.byte_index = 8'd0;
              s.sum_low    = 8'd0;
              s.sum_high   = 8'd0;
            end else begin
              status = StOk;
            end
          end
        endcase
        if (status != StPending) begin
          fend         = 1'b1;
          s.phase      = PhHunt;
          s.byte_index = 8'd0;
        end else if (s.phase == PhHeader) begin
          s.byte_index = (idx_inc >= HeaderLen) ? (HeaderLen - 8'd1) : idx_inc;
        end
      end
      PhPayload: begin
        role       = RolePayload;
        s.sum_low  = low_add;
        s.sum_high = high_add;
        if (idx_inc == state_i.held_length) begin
          s.phase      = PhPsum;
          s.byte_index = 8'd0;
        end else begin
          s.byte_index = idx_inc;
        end
      end
      default: begin
        role = RolePsum;
        if (state_i.byte_index == 8'd0) begin
          s.low_sum_matched = (b == state_i.sum_low);
          s.byte_index      = 8'd1;
        end else begin
          status = (state_i.low_sum_matched && b == state_i.sum_high) ?
                   StOk : StBadPsum;
          fend         = 1'b1;
          s.phase      = PhHunt;
          s.byte_index = 8'd0;
        end
      end
    endcase

    state_o                 = s;
    result_o.data_byte      = b;
    result_o.byte_role      = role;
    result_o.frame_end      = fend;
    result_o.status         = status;
    result_o.frame_type     = show ? s.held_type : 4'd0;
    result_o.ack_kind       = show ? s.held_ack : 2'd0;
    result_o.payload_length = show ? s.held_length : 8'd0;
  end

endmodule

`default_nettype wire

[hw/rtl/radio_packet_deframer.sv]
// ----------------------------------------------------------------------------
// radio_packet_deframer
// Checks radio frames byte by byte: sync, header fields, Fletcher-8 sums.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the rx channel (valid/ready), one item per byte.
// Every accepted byte yields exactly one result item on the out channel,
// carrying the byte, its role in the frame, a frame end flag, a status code
// and the header fields held so far.
// The result is registered: a byte accepted at one edge appears on the out
// channel after that edge. Throughput, set by the single result register, is
// one byte per cycle without a stall; the frame state updates at that edge.
// When the receiver stalls, the result register holds its item and rx_ready_o
// stays high only if the waiting item is taken in that cycle.
// The cfg channel writes the five setup registers by index; it is always
// ready and indexes beyond the list are ignored. Writes belong to idle time.
// Reset restores the default sync, direction and type codes, empties the
// result register and puts the block back to hunting for the first sync byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radio_packet_deframer
  import rpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration writes.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // Received bytes.
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  // Result items.
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic [1:0] byte_role_o,
  output logic       frame_end_o,
  output logic [2:0] status_o,
  output logic [3:0] frame_type_o,
  output logic [1:0] ack_kind_o,
  output logic [7:0] payload_length_o
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    rx_fire;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first     <= 8'd72;
      cfg_q.sync_second    <= 8'd101;
      cfg_q.dir_code_in    <= 8'd16;
      cfg_q.dir_code_out   <= 8'd32;
      cfg_q.data_type_code <= 4'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSyncFirst:  cfg_q.sync_first     <= cfg_data_i;
        CfgSyncSecond: cfg_q.sync_second    <= cfg_data_i;
        CfgDirIn:      cfg_q.dir_code_in    <= cfg_data_i;
        CfgDirOut:     cfg_q.dir_code_out   <= cfg_data_i;
        CfgDataType:   cfg_q.data_type_code <= cfg_data_i[3:0];
        default:       ;
      endcase
    end
  end

  // A byte is taken when the result register is free or being emptied.
  assign rx_ready_o = !out_valid_q || out_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  rpd_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .rx_byte_i (rx_byte_i),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  // Frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (rx_fire) begin
      state_q <= state_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_byte_o      = res_q.data_byte;
  assign byte_role_o      = res_q.byte_role;
  assign frame_end_o      = res_q.frame_end;
  assign status_o         = res_q.status;
  assign frame_type_o     = res_q.frame_type;
  assign ack_kind_o       = res_q.ack_kind;
  assign payload_length_o = res_q.payload_length;

endmodule

`default_nettype wire
